// ===== rtl/adaptive_replacement_cache_directory_unit_defines.svh =====
// Assertion macros for the adaptive replacement cache directory unit.
// Used by the top level only; needs signals named clock and reset in scope.
`ifndef ADAPTIVE_REPLACEMENT_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define ADAPTIVE_REPLACEMENT_CACHE_DIRECTORY_UNIT_DEFINES_SVH

// Checked property that is ignored while reset is high.
`define ARCD_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds during reset.
`define ARCD_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/arcd_pkg.sv =====
// Shared types and constants for the adaptive replacement cache directory.
// No dependencies; used by arcd_dir and the top level.
package arcd_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int TAG_BITS_DEFAULT = 32;
   localparam int REQ_W = 32;
   localparam int RSP_W = 40;

   typedef enum logic [2:0] {
      PL_EMPTY = 3'd0,
      PL_T1    = 3'd1,
      PL_T2    = 3'd2,
      PL_B1    = 3'd3,
      PL_B2    = 3'd4
   } place_type;

   typedef enum logic [2:0] {
      KIND_T1  = 3'd0,
      KIND_T2  = 3'd1,
      KIND_B1  = 3'd2,
      KIND_B2  = 3'd3,
      KIND_NEW = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_UNLINK,
      OP_LINK
   } dir_op_type;

   typedef struct packed {
      dir_op_type op;
      place_type  pl;
   } dir_cmd_type;

endpackage

// ===== rtl/arcd_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing; used by the top level to scale the adaptive target.
module arcd_div #(
   parameter int W = 6
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic          run_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W:0]    rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  den_ff;
   logic [W:0]    trial;
   logic          fits;

   always_comb begin
      trial = {rem_ff[W-1:0], quo_ff[W-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            quo_ff <= dividend;
            den_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= fits ? (trial - {1'b0, den_ff}) : trial;
            quo_ff <= {quo_ff[W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/arcd_dir.sv =====
// Directory storage: tag and slot memories, and the place and rank cells of every entry.
// Depends on arcd_pkg; driven by the sequencer in the top level.
module arcd_dir #(
   parameter int CAPACITY = arcd_pkg::CAPACITY_DEFAULT,
   parameter int TAG_BITS = arcd_pkg::TAG_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  arcd_pkg::dir_cmd_type               cmd,
   input  logic [$clog2(2*CAPACITY)-1:0]       cmd_idx,
   input  logic                                tag_we,
   input  logic [TAG_BITS-1:0]                 tag_wdata,
   input  logic                                slot_we,
   input  logic [$clog2(CAPACITY)-1:0]         slot_wdata,
   input  logic [$clog2(2*CAPACITY)-1:0]       rd_addr,
   output logic [TAG_BITS-1:0]                 tag_q,
   output logic [$clog2(CAPACITY)-1:0]         slot_q,
   input  logic [$clog2(2*CAPACITY)-1:0]       look_idx,
   output arcd_pkg::place_type                 look_place,
   output logic [$clog2(2*CAPACITY)-1:0]       look_rank,
   output logic [$clog2(2*CAPACITY+1)-1:0]     len_t1,
   output logic [$clog2(2*CAPACITY+1)-1:0]     len_t2,
   output logic [$clog2(2*CAPACITY+1)-1:0]     len_b1,
   output logic [$clog2(2*CAPACITY+1)-1:0]     len_b2
);

   localparam int DIR = 2 * CAPACITY;
   localparam int DW  = $clog2(DIR);
   localparam int LW  = $clog2(DIR + 1);
   localparam int SW  = $clog2(CAPACITY);

   logic [TAG_BITS-1:0] tag_mem_ff [DIR];
   logic [SW-1:0]       slot_mem_ff [DIR];
   logic [TAG_BITS-1:0] tag_q_ff;
   logic [SW-1:0]       slot_q_ff;

   arcd_pkg::place_type place_ff [DIR];
   arcd_pkg::place_type place_in [DIR];
   logic [DW-1:0]       rank_ff [DIR];
   logic [DW-1:0]       rank_in [DIR];
   logic [LW-1:0]       len_ff [5];
   logic [LW-1:0]       len_in [5];
   arcd_pkg::place_type sel_pl;
   logic [DW-1:0]       sel_rank;

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem_ff[cmd_idx] <= tag_wdata;
      end
      if (slot_we) begin
         slot_mem_ff[cmd_idx] <= slot_wdata;
      end
      tag_q_ff  <= tag_mem_ff[rd_addr];
      slot_q_ff <= slot_mem_ff[rd_addr];
   end

   always_comb begin
      sel_pl   = place_ff[cmd_idx];
      sel_rank = rank_ff[cmd_idx];
      place_in = place_ff;
      rank_in  = rank_ff;
      len_in   = len_ff;
      unique case (cmd.op)
         arcd_pkg::OP_UNLINK: begin
            if (sel_pl != arcd_pkg::PL_EMPTY) begin
               for (int i = 0; i < DIR; i++) begin
                  if (DW'(i) != cmd_idx && place_ff[i] == sel_pl && rank_ff[i] > sel_rank) begin
                     rank_in[i] = rank_ff[i] - 1'b1;
                  end
               end
               if (len_ff[sel_pl] != '0) begin
                  len_in[sel_pl] = len_ff[sel_pl] - 1'b1;
               end
               place_in[cmd_idx] = arcd_pkg::PL_EMPTY;
               rank_in[cmd_idx]  = '0;
            end
         end
         arcd_pkg::OP_LINK: begin
            for (int i = 0; i < DIR; i++) begin
               if (place_ff[i] == cmd.pl) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            place_in[cmd_idx] = cmd.pl;
            rank_in[cmd_idx]  = '0;
            len_in[cmd.pl]    = len_ff[cmd.pl] + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIR; i++) begin
            place_ff[i] <= arcd_pkg::PL_EMPTY;
            rank_ff[i]  <= '0;
         end
         for (int k = 0; k < 5; k++) begin
            len_ff[k] <= '0;
         end
      end else begin
         place_ff <= place_in;
         rank_ff  <= rank_in;
         len_ff   <= len_in;
      end
   end

   assign tag_q      = tag_q_ff;
   assign slot_q     = slot_q_ff;
   assign look_place = place_ff[look_idx];
   assign look_rank  = rank_ff[look_idx];
   assign len_t1     = len_ff[arcd_pkg::PL_T1];
   assign len_t2     = len_ff[arcd_pkg::PL_T2];
   assign len_b1     = len_ff[arcd_pkg::PL_B1];
   assign len_b2     = len_ff[arcd_pkg::PL_B2];

endmodule

// ===== rtl/adaptive_replacement_cache_directory_unit.sv =====
// Adaptive replacement cache directory: request sequencer, slot map and hit counter.
// Depends on arcd_pkg, arcd_dir, arcd_div and the defines header.
//
// Each beat on the req_ channel carries one page number. The unit classifies it
// against the resident lists T1 and T2 and the ghost lists B1 and B2, updates the
// lists, the adaptive target and the slot map, and returns one beat on the rsp_
// channel with the hit kind, the slot now holding the page and the hit count.
// One request is handled at a time; req_tready is high only while the sequencer
// is idle. A request costs one sweep of the 2*CAPACITY directory entries (one
// entry per cycle through the tag memory read port), then the list updates, and
// for a miss a second sweep; ghost hits may also run the divider, and misses and
// ghost hits add a search for a free slot among the CAPACITY slots.
// A finished result waits in the output register; the next request is taken
// meanwhile, and the sequencer holds its result only if the previous one is
// still stalled by rsp_tready. Reset empties all lists and frees every slot.
module adaptive_replacement_cache_directory_unit #(
   parameter int CAPACITY = arcd_pkg::CAPACITY_DEFAULT,
   parameter int TAG_BITS = arcd_pkg::TAG_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [arcd_pkg::REQ_W-1:0] req_tdata,   // [31:0] page_number
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [arcd_pkg::RSP_W-1:0] rsp_tdata    // [2:0] hit_kind, [6:3] slot_index,
                                                   // [38:7] hit_total
);

   `include "adaptive_replacement_cache_directory_unit_defines.svh"

   localparam int DIR = 2 * CAPACITY;
   localparam int DW  = $clog2(DIR);
   localparam int LW  = $clog2(DIR + 1);
   localparam int SW  = $clog2(CAPACITY);
   localparam int PW  = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_ADJP, S_DROP, S_REPL, S_REPL_LINK,
      S_FREE, S_E_UNLINK, S_E_LINK, S_TAKE, S_FINISH
   } state_type;

   typedef enum logic [1:0] {P_HIT, P_GHOST, P_NEW} path_type;

   state_type           state_ff;
   path_type            path_ff;
   logic                pass2_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [DW:0]         sc_ff;
   logic                look_vld_ff;
   logic [DW-1:0]       look_idx_ff;
   logic                match_ff;
   arcd_pkg::place_type match_pl_ff;
   logic [SW-1:0]       match_slot_ff;
   logic [DW-1:0]       e_ff;
   logic                emp_ok_ff;
   logic [DW-1:0]       emp_ff;
   logic                lru_ok_ff [5];
   logic [DW-1:0]       lru_idx_ff [5];
   logic [DW-1:0]       lru_rank_ff [5];
   logic [SW-1:0]       lru_slot_ff [5];
   logic [SW-1:0]       zero_slot_ff;
   arcd_pkg::kind_type  kind_ff;
   arcd_pkg::place_type drop_pl_ff;
   arcd_pkg::place_type link_pl_ff;
   logic                repl_ff;
   logic                in_b2_ff;
   logic [DW-1:0]       vict_ff;
   arcd_pkg::place_type vict_dest_ff;
   logic [LW-1:0]       delta_ff;
   logic [PW-1:0]       p_ff;
   logic                slot_busy_ff [CAPACITY];
   logic [SW-1:0]       sp_ff;
   logic [SW-1:0]       slot_ff;
   logic [31:0]         hit_count_ff;
   logic                rsp_valid_ff;
   logic [arcd_pkg::RSP_W-1:0] rsp_data_ff;

   arcd_pkg::dir_cmd_type cmd;
   logic [DW-1:0]       cmd_idx;
   logic                tag_we;
   logic                slot_we;
   logic [TAG_BITS-1:0] tag_q;
   logic [SW-1:0]       slot_q;
   arcd_pkg::place_type look_place;
   logic [DW-1:0]       look_rank;
   logic [LW-1:0]       len_t1, len_t2, len_b1, len_b2;

   logic                div_start;
   logic                div_done;
   logic [LW-1:0]       div_n, div_d, div_q;

   logic [63:0]         page_wide;
   logic [TAG_BITS-1:0] req_tag;
   logic                use_t1;
   arcd_pkg::place_type vic_first, vic_second, vic_pl;
   logic                vic_ok;
   logic [LW+1:0]       l1, l2, l12;
   logic [LW:0]         psum;
   logic [SW+3:0]       slot_wide;
   logic                accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = state_ff == S_IDLE;
   assign page_wide  = {32'b0, req_tdata};
   assign req_tag    = page_wide[TAG_BITS-1:0];

   arcd_dir #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_dir (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_idx    (cmd_idx),
      .tag_we     (tag_we),
      .tag_wdata  (tag_ff),
      .slot_we    (slot_we),
      .slot_wdata (slot_ff),
      .rd_addr    (sc_ff[DW-1:0]),
      .tag_q      (tag_q),
      .slot_q     (slot_q),
      .look_idx   (look_idx_ff),
      .look_place (look_place),
      .look_rank  (look_rank),
      .len_t1     (len_t1),
      .len_t2     (len_t2),
      .len_b1     (len_b1),
      .len_b2     (len_b2)
   );

   arcd_div #(.W(LW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      div_n     = (match_pl_ff == arcd_pkg::PL_B1) ? len_b2 : len_b1;
      div_d     = (match_pl_ff == arcd_pkg::PL_B1) ? len_b1 : len_b2;
      div_start = state_ff == S_DECIDE && match_ff && div_d != '0 &&
                  (match_pl_ff == arcd_pkg::PL_B1 || match_pl_ff == arcd_pkg::PL_B2);

      use_t1 = len_t1 != '0 &&
               ((in_b2_ff && len_t1 == LW'(p_ff)) || len_t1 > LW'(p_ff));
      vic_first  = use_t1 ? arcd_pkg::PL_T1 : arcd_pkg::PL_T2;
      vic_second = use_t1 ? arcd_pkg::PL_T2 : arcd_pkg::PL_T1;
      vic_ok     = lru_ok_ff[vic_first] || lru_ok_ff[vic_second];
      vic_pl     = lru_ok_ff[vic_first] ? vic_first : vic_second;

      l1   = (LW+2)'(len_b1) + (LW+2)'(len_t1);
      l2   = (LW+2)'(len_b2) + (LW+2)'(len_t2);
      l12  = l1 + l2;
      psum = (LW+1)'(p_ff) + (LW+1)'(delta_ff);
      slot_wide = {4'b0, slot_ff};

      cmd.op  = arcd_pkg::OP_NONE;
      cmd.pl  = arcd_pkg::PL_EMPTY;
      cmd_idx = e_ff;
      tag_we  = 1'b0;
      slot_we = 1'b0;
      unique case (state_ff)
         S_DROP: begin
            cmd_idx = lru_idx_ff[drop_pl_ff];
            if (lru_ok_ff[drop_pl_ff]) begin
               cmd.op = arcd_pkg::OP_UNLINK;
            end
         end
         S_REPL: begin
            cmd_idx = lru_idx_ff[vic_pl];
            if (vic_ok) begin
               cmd.op = arcd_pkg::OP_UNLINK;
            end
         end
         S_REPL_LINK: begin
            cmd_idx = vict_ff;
            cmd.op  = arcd_pkg::OP_LINK;
            cmd.pl  = vict_dest_ff;
         end
         S_E_UNLINK: begin
            cmd.op = arcd_pkg::OP_UNLINK;
         end
         S_E_LINK: begin
            cmd.op = arcd_pkg::OP_LINK;
            cmd.pl = link_pl_ff;
            tag_we = path_ff == P_NEW;
         end
         S_FINISH: begin
            slot_we = path_ff != P_HIT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p_ff         <= '0;
         hit_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         look_vld_ff  <= 1'b0;
         for (int s = 0; s < CAPACITY; s++) begin
            slot_busy_ff[s] <= 1'b0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  tag_ff      <= req_tag;
                  pass2_ff    <= 1'b0;
                  sc_ff       <= '0;
                  look_vld_ff <= 1'b0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               look_vld_ff <= sc_ff < (DW+1)'(DIR);
               look_idx_ff <= sc_ff[DW-1:0];
               if (sc_ff < (DW+1)'(DIR)) begin
                  sc_ff <= sc_ff + 1'b1;
               end
               if (sc_ff == '0) begin
                  match_ff  <= 1'b0;
                  emp_ok_ff <= 1'b0;
                  for (int k = 0; k < 5; k++) begin
                     lru_ok_ff[k] <= 1'b0;
                  end
               end
               if (look_vld_ff) begin
                  if (!match_ff && look_place != arcd_pkg::PL_EMPTY && tag_q == tag_ff) begin
                     match_ff      <= 1'b1;
                     e_ff          <= look_idx_ff;
                     match_pl_ff   <= look_place;
                     match_slot_ff <= slot_q;
                  end
                  if (!emp_ok_ff && look_place == arcd_pkg::PL_EMPTY) begin
                     emp_ok_ff <= 1'b1;
                     emp_ff    <= look_idx_ff;
                  end
                  if (look_place != arcd_pkg::PL_EMPTY &&
                      (!lru_ok_ff[look_place] || look_rank > lru_rank_ff[look_place])) begin
                     lru_ok_ff[look_place]   <= 1'b1;
                     lru_idx_ff[look_place]  <= look_idx_ff;
                     lru_rank_ff[look_place] <= look_rank;
                     lru_slot_ff[look_place] <= slot_q;
                  end
                  if (look_idx_ff == '0) begin
                     zero_slot_ff <= slot_q;
                  end
               end
               if (sc_ff == (DW+1)'(DIR)) begin
                  state_ff <= pass2_ff ? S_FREE : S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (match_ff && (match_pl_ff == arcd_pkg::PL_T1 ||
                                match_pl_ff == arcd_pkg::PL_T2)) begin
                  path_ff       <= P_HIT;
                  kind_ff       <= (match_pl_ff == arcd_pkg::PL_T1) ?
                                   arcd_pkg::KIND_T1 : arcd_pkg::KIND_T2;
                  slot_ff       <= match_slot_ff;
                  link_pl_ff    <= arcd_pkg::PL_T2;
                  if (hit_count_ff != 32'hFFFF_FFFF) begin
                     hit_count_ff <= hit_count_ff + 1'b1;
                  end
                  state_ff      <= S_E_UNLINK;
               end else if (match_ff) begin
                  path_ff    <= P_GHOST;
                  kind_ff    <= (match_pl_ff == arcd_pkg::PL_B1) ?
                                arcd_pkg::KIND_B1 : arcd_pkg::KIND_B2;
                  in_b2_ff   <= match_pl_ff == arcd_pkg::PL_B2;
                  link_pl_ff <= arcd_pkg::PL_T2;
                  if (div_d == '0) begin
                     delta_ff <= LW'(1);
                     state_ff <= S_ADJP;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end else begin
                  path_ff    <= P_NEW;
                  kind_ff    <= arcd_pkg::KIND_NEW;
                  link_pl_ff <= arcd_pkg::PL_T1;
                  in_b2_ff   <= 1'b0;
                  pass2_ff   <= 1'b1;
                  sc_ff      <= '0;
                  look_vld_ff <= 1'b0;
                  if (l1 == (LW+2)'(CAPACITY)) begin
                     if (len_t1 < LW'(CAPACITY)) begin
                        drop_pl_ff <= arcd_pkg::PL_B1;
                        repl_ff    <= 1'b1;
                     end else begin
                        drop_pl_ff <= arcd_pkg::PL_T1;
                        repl_ff    <= 1'b0;
                     end
                     state_ff <= S_DROP;
                  end else if (l1 < (LW+2)'(CAPACITY) && l12 >= (LW+2)'(CAPACITY)) begin
                     repl_ff <= 1'b1;
                     if (l12 == (LW+2)'(DIR)) begin
                        drop_pl_ff <= arcd_pkg::PL_B2;
                        state_ff   <= S_DROP;
                     end else begin
                        state_ff <= S_REPL;
                     end
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  delta_ff <= (div_q == '0) ? LW'(1) : div_q;
                  state_ff <= S_ADJP;
               end
            end
            S_ADJP: begin
               if (!in_b2_ff) begin
                  p_ff <= (psum > (LW+1)'(CAPACITY)) ? PW'(CAPACITY) : PW'(psum);
               end else begin
                  p_ff <= (LW'(p_ff) > delta_ff) ? PW'(LW'(p_ff) - delta_ff) : '0;
               end
               repl_ff  <= 1'b1;
               state_ff <= S_REPL;
            end
            S_DROP: begin
               if (lru_ok_ff[drop_pl_ff] && drop_pl_ff == arcd_pkg::PL_T1) begin
                  slot_busy_ff[lru_slot_ff[drop_pl_ff]] <= 1'b0;
               end
               state_ff <= repl_ff ? S_REPL : S_SCAN;
            end
            S_REPL: begin
               if (vic_ok) begin
                  slot_busy_ff[lru_slot_ff[vic_pl]] <= 1'b0;
                  vict_ff      <= lru_idx_ff[vic_pl];
                  vict_dest_ff <= (vic_pl == arcd_pkg::PL_T1) ?
                                  arcd_pkg::PL_B1 : arcd_pkg::PL_B2;
                  state_ff     <= S_REPL_LINK;
               end else begin
                  state_ff <= (path_ff == P_NEW) ? S_SCAN : S_E_UNLINK;
               end
            end
            S_REPL_LINK: begin
               state_ff <= (path_ff == P_NEW) ? S_SCAN : S_E_UNLINK;
            end
            S_FREE: begin
               if (emp_ok_ff) begin
                  e_ff <= emp_ff;
               end else if (lru_ok_ff[arcd_pkg::PL_B2]) begin
                  e_ff <= lru_idx_ff[arcd_pkg::PL_B2];
               end else if (lru_ok_ff[arcd_pkg::PL_B1]) begin
                  e_ff <= lru_idx_ff[arcd_pkg::PL_B1];
               end else begin
                  e_ff <= '0;
                  slot_busy_ff[zero_slot_ff] <= 1'b0;
               end
               state_ff <= S_E_UNLINK;
            end
            S_E_UNLINK: begin
               state_ff <= S_E_LINK;
            end
            S_E_LINK: begin
               sp_ff    <= '0;
               state_ff <= (path_ff == P_HIT) ? S_FINISH : S_TAKE;
            end
            S_TAKE: begin
               if (!slot_busy_ff[sp_ff]) begin
                  slot_busy_ff[sp_ff] <= 1'b1;
                  slot_ff  <= sp_ff;
                  state_ff <= S_FINISH;
               end else if (sp_ff == SW'(CAPACITY - 1)) begin
                  slot_busy_ff[0] <= 1'b1;
                  slot_ff  <= '0;
                  state_ff <= S_FINISH;
               end else begin
                  sp_ff <= sp_ff + 1'b1;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, hit_count_ff, slot_wide[3:0], kind_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ARCD_CHECK(a_target_range, (p_ff <= PW'(CAPACITY)), "adaptive target above capacity")
   `ARCD_CHECK(a_take_marks_busy, (state_ff == S_TAKE && !slot_busy_ff[sp_ff]) |=> slot_busy_ff[$past(sp_ff)], "taken slot not marked busy")
   `ARCD_CHECK(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH, "response beat raised outside finish")

endmodule
